[rtl/core/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, constants and the CRC7 helper of the SPI-mode SD card
// block transfer sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES      = 512;
    localparam int WRITE_POLL_LIMIT = 10;

    localparam int CNT_W   = $clog2(BLOCK_BYTES + 1);
    localparam int FIELD_W = 10;
    localparam int CLAMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int POLL_W  = 16;

    localparam logic [CNT_W-1:0]   BLOCK_CNT      = CNT_W'(BLOCK_BYTES);
    localparam logic [CLAMP_W-1:0] BLOCK_CLAMP    = CLAMP_W'(BLOCK_BYTES);
    localparam logic [POLL_W-1:0]  WR_POLL_LIMIT  = POLL_W'(WRITE_POLL_LIMIT);
    localparam logic [POLL_W-1:0]  RETRIES_RESET  = 16'd255;

    localparam logic [CNT_W-1:0] FRAME_BODY_LAST = CNT_W'(5);
    localparam logic [CNT_W-1:0] FRAME_END       = CNT_W'(6);
    localparam logic [CNT_W-1:0] RESP_KEEP_IDX   = CNT_W'(1);
    localparam logic [CNT_W-1:0] RESP_END        = CNT_W'(8);
    localparam logic [CNT_W-1:0] CRC_BYTES       = CNT_W'(2);

    localparam logic [1:0] OP_EXCHANGE = 2'd0;
    localparam logic [1:0] OP_COMMAND  = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_WRITE    = 2'd3;

    localparam logic [7:0] CMD_START   = 8'h40;
    localparam logic [7:0] CMD_READ17  = 8'h40 | 8'd17;
    localparam logic [7:0] CMD_WRITE24 = 8'h40 | 8'd24;
    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] DRESP_MASK  = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'h09;

    typedef enum logic [15:0] {
        PH_IDLE       = 16'b0000_0000_0000_0001,
        PH_CMD_FRAME  = 16'b0000_0000_0000_0010,
        PH_CMD_RESP   = 16'b0000_0000_0000_0100,
        PH_RD_FRAME   = 16'b0000_0000_0000_1000,
        PH_RD_POLL0   = 16'b0000_0000_0001_0000,
        PH_RD_POLLTOK = 16'b0000_0000_0010_0000,
        PH_RD_SKIP    = 16'b0000_0000_0100_0000,
        PH_RD_DATA    = 16'b0000_0000_1000_0000,
        PH_RD_REST    = 16'b0000_0001_0000_0000,
        PH_RD_CRC     = 16'b0000_0010_0000_0000,
        PH_RD_BUSY    = 16'b0000_0100_0000_0000,
        PH_WR_FRAME   = 16'b0000_1000_0000_0000,
        PH_WR_POLL0   = 16'b0001_0000_0000_0000,
        PH_WR_TOKEN   = 16'b0010_0000_0000_0000,
        PH_WR_DATA    = 16'b0100_0000_0000_0000,
        PH_WR_CRC     = 16'b1000_0000_0000_0000
    } phase_t;

    typedef struct packed {
        logic       exchange_now;
        logic [7:0] mosi_byte;
        logic       chip_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       write_taken;
        logic       done_res;
        logic [7:0] response_byte;
    } result_t;

    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic [7:0] c;
        r = {1'b0, crc};
        c = data;
        for (int k = 0; k < 8; k++) begin
            r = {r[6:0], 1'b0};
            if (c[7] ^ r[7]) begin
                r = r ^ CRC_POLY;
            end
            c = {c[6:0], 1'b0};
        end
        return r[6:0];
    endfunction

endpackage

[rtl/core/sd_spi_block_transfer_sequencer_core.sv]
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_sequencer_core
// SPI-mode SD card sequencer for commands, single block reads and writes.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry either a request (operation 1..3,
// taken while no transfer runs) or the MISO byte of the exchange asked for
// by the previous result (operation 0). Every input beat yields exactly one
// result beat (out_valid/out_ready): an exchange request with mosi_byte,
// a delivered read byte, a consumed write byte, done_res at the end, or a
// beat that asks for no exchange. wait_retries is written through
// cfg_write_enable/cfg_write_data; the user must write it only while no
// transfer is open, as the block itself does not enforce this.
// Throughput: one beat per cycle while in_ready is high; the whole step
// (phase update, byte-wide CRC7) is one combinational pass into the result
// register. A two-entry result buffer (output register plus skid register)
// lets an input beat be taken while a result waits; in_ready drops only
// when both entries are full, so a stalled receiver holds back the sender
// after two results. Reset empties the buffer, sets the phase idle, clears
// counters and sets wait_retries to 255.
// ----------------------------------------------------------------------------
module sd_spi_block_transfer_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [5:0]  command_index,
    input  logic [31:0] argument,
    input  logic [9:0]  skip_count,
    input  logic [9:0]  read_length,
    input  logic [7:0]  miso_byte,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        exchange_now,
    output logic [7:0]  mosi_byte,
    output logic        chip_select,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        write_taken,
    output logic        done_res,
    output logic [7:0]  response_byte
);

    localparam int CW = sdspi_pkg::CNT_W;
    localparam int PW = sdspi_pkg::POLL_W;
    localparam int KW = sdspi_pkg::CLAMP_W;

    logic [PW-1:0]        wait_retries_reg;
    sdspi_pkg::phase_t    phase_reg, phase_next;
    logic [CW-1:0]        byte_cnt_reg, byte_cnt_next;
    logic [PW-1:0]        poll_cnt_reg, poll_cnt_next;
    logic [31:0]          frame_reg, frame_next;
    logic [6:0]           crc_reg, crc_next;
    logic [CW-1:0]        skip_reg, skip_next;
    logic [CW-1:0]        deliver_reg, deliver_next;
    logic [7:0]           kept_reg, kept_next;

    sdspi_pkg::result_t   res;
    sdspi_pkg::result_t   out_res_reg;
    sdspi_pkg::result_t   skid_res_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    logic                 accept;
    logic                 pop;

    sdspi_pkg::phase_t    tgt;
    logic                 enter;
    logic                 no_retries;
    logic [7:0]           first_byte;
    logic [KW-1:0]        sk_w;
    logic [KW-1:0]        ln_w;
    logic [KW-1:0]        room_w;

    assign in_ready   = !skid_valid_reg;
    assign accept     = in_valid && in_ready;
    assign pop        = out_valid_reg && out_ready;
    assign no_retries = (wait_retries_reg == '0);

    always_comb
    begin
        phase_next   = phase_reg;
        byte_cnt_next = byte_cnt_reg;
        poll_cnt_next = poll_cnt_reg;
        frame_next   = frame_reg;
        crc_next     = crc_reg;
        skip_next    = skip_reg;
        deliver_next = deliver_reg;
        kept_next    = kept_reg;
        res          = '0;
        tgt          = phase_reg;
        enter        = 1'b0;
        first_byte   = '0;
        sk_w         = '0;
        ln_w         = '0;
        room_w       = '0;

        if (phase_reg == sdspi_pkg::PH_IDLE) begin
            if (operation != sdspi_pkg::OP_EXCHANGE) begin
                byte_cnt_next = '0;
                poll_cnt_next = '0;
                frame_next    = argument;
                kept_next     = '0;
                skip_next     = '0;
                deliver_next  = '0;
                if (operation == sdspi_pkg::OP_COMMAND) begin
                    phase_next = sdspi_pkg::PH_CMD_FRAME;
                    first_byte = {2'b00, command_index} | sdspi_pkg::CMD_START;
                end else if (operation == sdspi_pkg::OP_READ) begin
                    phase_next = sdspi_pkg::PH_RD_FRAME;
                    first_byte = sdspi_pkg::CMD_READ17;
                    sk_w = KW'(skip_count);
                    if (sk_w > sdspi_pkg::BLOCK_CLAMP) begin
                        sk_w = sdspi_pkg::BLOCK_CLAMP;
                    end
                    room_w = sdspi_pkg::BLOCK_CLAMP - sk_w;
                    ln_w   = KW'(read_length);
                    if (ln_w > room_w) begin
                        ln_w = room_w;
                    end
                    skip_next    = CW'(sk_w);
                    deliver_next = CW'(ln_w);
                end else begin
                    phase_next = sdspi_pkg::PH_WR_FRAME;
                    first_byte = sdspi_pkg::CMD_WRITE24;
                end
                crc_next         = sdspi_pkg::crc7_byte(7'd0, first_byte);
                res.exchange_now = 1'b1;
                res.mosi_byte    = first_byte;
                res.chip_select  = 1'b1;
            end
        end else if (operation != sdspi_pkg::OP_EXCHANGE) begin
            res.chip_select = 1'b1;
        end else begin
            case (phase_reg)
                sdspi_pkg::PH_CMD_FRAME, sdspi_pkg::PH_RD_FRAME, sdspi_pkg::PH_WR_FRAME:
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_next >= sdspi_pkg::FRAME_END) begin
                        enter = 1'b1;
                        if (phase_reg == sdspi_pkg::PH_CMD_FRAME) begin
                            tgt = sdspi_pkg::PH_CMD_RESP;
                        end else if (phase_reg == sdspi_pkg::PH_RD_FRAME) begin
                            tgt = sdspi_pkg::PH_RD_POLL0;
                        end else begin
                            tgt = sdspi_pkg::PH_WR_POLL0;
                        end
                    end
                end
                sdspi_pkg::PH_CMD_RESP:
                begin
                    if (byte_cnt_reg == sdspi_pkg::RESP_KEEP_IDX) begin
                        kept_next = miso_byte;
                    end
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_next >= sdspi_pkg::RESP_END) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_IDLE;
                    end
                end
                sdspi_pkg::PH_RD_POLL0:
                begin
                    poll_cnt_next = poll_cnt_reg + 1'b1;
                    if (miso_byte == sdspi_pkg::R1_READY || poll_cnt_next >= wait_retries_reg) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_RD_POLLTOK;
                    end
                end
                sdspi_pkg::PH_RD_POLLTOK:
                begin
                    poll_cnt_next = poll_cnt_reg + 1'b1;
                    if (miso_byte == sdspi_pkg::TOKEN_START
                        || poll_cnt_next >= wait_retries_reg) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_RD_SKIP;
                    end
                end
                sdspi_pkg::PH_RD_SKIP:
                begin
                    skip_next     = skip_reg - 1'b1;
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    enter         = 1'b1;
                    tgt           = sdspi_pkg::PH_RD_SKIP;
                end
                sdspi_pkg::PH_RD_DATA:
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = miso_byte;
                    deliver_next   = deliver_reg - 1'b1;
                    byte_cnt_next  = byte_cnt_reg + 1'b1;
                    enter          = 1'b1;
                    tgt            = sdspi_pkg::PH_RD_DATA;
                end
                sdspi_pkg::PH_RD_REST:
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    enter         = 1'b1;
                    tgt           = sdspi_pkg::PH_RD_REST;
                end
                sdspi_pkg::PH_RD_CRC:
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_next >= sdspi_pkg::CRC_BYTES) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_RD_BUSY;
                    end
                end
                sdspi_pkg::PH_RD_BUSY:
                begin
                    poll_cnt_next = poll_cnt_reg + 1'b1;
                    if (miso_byte == sdspi_pkg::IDLE_BYTE || poll_cnt_next >= wait_retries_reg) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_IDLE;
                    end
                end
                sdspi_pkg::PH_WR_POLL0:
                begin
                    poll_cnt_next = poll_cnt_reg + 1'b1;
                    if (miso_byte == sdspi_pkg::R1_READY
                        || poll_cnt_next >= sdspi_pkg::WR_POLL_LIMIT) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_WR_TOKEN;
                    end
                end
                sdspi_pkg::PH_WR_TOKEN:
                begin
                    poll_cnt_next = poll_cnt_reg + 1'b1;
                    if ((miso_byte & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_MASK
                        || poll_cnt_next >= sdspi_pkg::WR_POLL_LIMIT) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_WR_DATA;
                    end
                end
                sdspi_pkg::PH_WR_DATA:
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_next >= sdspi_pkg::BLOCK_CNT) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_WR_CRC;
                    end
                end
                sdspi_pkg::PH_WR_CRC:
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_next >= sdspi_pkg::CRC_BYTES) begin
                        enter = 1'b1;
                        tgt   = sdspi_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    enter = 1'b1;
                    tgt   = sdspi_pkg::PH_IDLE;
                end
            endcase

            // stage entry, passing over stages that need no exchange
            if (enter) begin
                if (tgt == sdspi_pkg::PH_RD_POLL0) begin
                    byte_cnt_next = '0;
                    poll_cnt_next = '0;
                    if (no_retries) begin
                        tgt = sdspi_pkg::PH_RD_POLLTOK;
                    end
                end
                if (tgt == sdspi_pkg::PH_RD_POLLTOK) begin
                    poll_cnt_next = '0;
                    if (no_retries) begin
                        tgt = sdspi_pkg::PH_RD_SKIP;
                    end
                end
                if (tgt == sdspi_pkg::PH_RD_SKIP && skip_next == '0) begin
                    tgt = sdspi_pkg::PH_RD_DATA;
                end
                if (tgt == sdspi_pkg::PH_RD_DATA && deliver_next == '0) begin
                    tgt = sdspi_pkg::PH_RD_REST;
                end
                if (tgt == sdspi_pkg::PH_RD_REST && byte_cnt_next >= sdspi_pkg::BLOCK_CNT) begin
                    tgt = sdspi_pkg::PH_RD_CRC;
                end
                if (tgt == sdspi_pkg::PH_CMD_RESP || tgt == sdspi_pkg::PH_RD_CRC
                    || tgt == sdspi_pkg::PH_WR_CRC || tgt == sdspi_pkg::PH_WR_DATA) begin
                    byte_cnt_next = '0;
                end
                if (tgt == sdspi_pkg::PH_RD_BUSY) begin
                    poll_cnt_next = '0;
                    if (no_retries) begin
                        tgt = sdspi_pkg::PH_IDLE;
                    end
                end
                if (tgt == sdspi_pkg::PH_WR_POLL0 || tgt == sdspi_pkg::PH_WR_TOKEN) begin
                    poll_cnt_next = '0;
                end
            end
            phase_next = tgt;

            if (tgt == sdspi_pkg::PH_IDLE) begin
                res.done_res      = 1'b1;
                res.response_byte = kept_next;
            end else begin
                res.exchange_now = 1'b1;
                res.chip_select  = 1'b1;
                case (tgt)
                    sdspi_pkg::PH_CMD_FRAME, sdspi_pkg::PH_RD_FRAME, sdspi_pkg::PH_WR_FRAME:
                    begin
                        if (byte_cnt_next < sdspi_pkg::FRAME_BODY_LAST) begin
                            res.mosi_byte = frame_reg[31:24];
                            frame_next    = {frame_reg[23:0], 8'h00};
                            crc_next      = sdspi_pkg::crc7_byte(crc_reg, frame_reg[31:24]);
                        end else if (tgt == sdspi_pkg::PH_CMD_FRAME) begin
                            res.mosi_byte = {crc_reg, 1'b1};
                        end else if (tgt == sdspi_pkg::PH_RD_FRAME) begin
                            res.mosi_byte = sdspi_pkg::TOKEN_START;
                        end else begin
                            res.mosi_byte = sdspi_pkg::IDLE_BYTE;
                        end
                    end
                    sdspi_pkg::PH_WR_TOKEN:
                    begin
                        res.mosi_byte = sdspi_pkg::TOKEN_START;
                    end
                    sdspi_pkg::PH_WR_DATA:
                    begin
                        res.mosi_byte   = write_byte;
                        res.write_taken = 1'b1;
                    end
                    default:
                    begin
                        res.mosi_byte = sdspi_pkg::IDLE_BYTE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wait_retries_reg <= sdspi_pkg::RETRIES_RESET;
            phase_reg        <= sdspi_pkg::PH_IDLE;
            byte_cnt_reg     <= '0;
            poll_cnt_reg     <= '0;
            frame_reg        <= '0;
            crc_reg          <= '0;
            skip_reg         <= '0;
            deliver_reg      <= '0;
            kept_reg         <= '0;
        end else begin
            if (cfg_write_enable) begin
                wait_retries_reg <= cfg_write_data;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                byte_cnt_reg <= byte_cnt_next;
                poll_cnt_reg <= poll_cnt_next;
                frame_reg    <= frame_next;
                crc_reg      <= crc_next;
                skip_reg     <= skip_next;
                deliver_reg  <= deliver_next;
                kept_reg     <= kept_next;
            end
        end
    end

    // result buffer: output register plus skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (out_valid_reg && !pop) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_res_reg <= skid_res_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_res_reg <= res;
            end else begin
                out_res_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign exchange_now  = out_res_reg.exchange_now;
    assign mosi_byte     = out_res_reg.mosi_byte;
    assign chip_select   = out_res_reg.chip_select;
    assign data_valid    = out_res_reg.data_valid;
    assign data_byte     = out_res_reg.data_byte;
    assign write_taken   = out_res_reg.write_taken;
    assign done_res      = out_res_reg.done_res;
    assign response_byte = out_res_reg.response_byte;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_done_no_exchange: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_res && exchange_now))
        else $error("done beat also asks for an exchange");

    a_data_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && data_valid) |-> (exchange_now && chip_select))
        else $error("read byte delivered outside an open transfer");

    a_write_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && write_taken) |-> (exchange_now && chip_select && !data_valid))
        else $error("write byte taken outside an open transfer");

    a_idle_no_select: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == sdspi_pkg::PH_IDLE && operation == sdspi_pkg::OP_EXCHANGE)
        |=> (phase_reg == sdspi_pkg::PH_IDLE))
        else $error("idle exchange beat started a transfer");

endmodule

[tb/sd_spi_block_transfer_sequencer_core_tb.sv]
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_sequencer_core_tb
// Self-checking bench for the SPI-mode SD card transfer sequencer. The bench
// acts as the card: a state-aware responder answers every exchange the block
// asks for, and a cycle-free model of the sequencer predicts each result beat.
// A short table of directed beats (some with hand-written results) comes
// first, then random transfers under several wait_retries settings, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module sd_spi_block_transfer_sequencer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sdspi_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [9:0]  skip;
        logic [9:0]  len;
        logic [7:0]  miso;
        logic [7:0]  wbyte;
    } beat_t;

    typedef struct packed {
        beat_t   item;
        logic    typed;
        result_t want;
        logic    finish;
    } step_row_t;

    localparam result_t NO_FIELDS   = '0;
    localparam result_t SELECT_ONLY = result_t'({1'b0, 8'h00, 1'b1, 1'b0, 8'h00,
                                                  1'b0, 1'b0, 8'h00});

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_enable;
    logic [15:0] cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [9:0]  skip_count;
    logic [9:0]  read_length;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
    logic        out_valid;
    logic        out_ready;
    logic        exchange_now;
    logic [7:0]  mosi_byte;
    logic        chip_select;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        write_taken;
    logic        done_res;
    logic [7:0]  response_byte;

    // sequencer model state
    phase_t      sq_phase;
    logic [9:0]  sq_count;
    logic [15:0] sq_polls;
    logic [31:0] sq_frame;
    logic [6:0]  sq_crc;
    logic [9:0]  sq_skip;
    logic [9:0]  sq_deliver;
    logic [7:0]  sq_resp;
    logic [15:0] retry_limit;

    result_t     results_due[$];
    int          bad_results = 0;
    int          result_index = 0;
    bit          no_idle = 1'b0;

    sd_spi_block_transfer_sequencer_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .command_index    (command_index),
        .argument         (argument),
        .skip_count       (skip_count),
        .read_length      (read_length),
        .miso_byte        (miso_byte),
        .write_byte       (write_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .exchange_now     (exchange_now),
        .mosi_byte        (mosi_byte),
        .chip_select      (chip_select),
        .data_valid       (data_valid),
        .data_byte        (data_byte),
        .write_taken      (write_taken),
        .done_res         (done_res),
        .response_byte    (response_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [6:0] crc7_next(input logic [6:0] acc, input logic [7:0] d);
        logic [7:0] sh;
        sh = {1'b0, acc};
        for (int i = 7; i >= 0; i--)
        begin
            sh = {sh[6:0], 1'b0};
            if (sh[7] ^ d[i])
                sh = sh ^ CRC_POLY;
        end
        return sh[6:0];
    endfunction

    // Enter a stage; stages with nothing to exchange fall through.
    function automatic void enter_stage(input phase_t p);
        phase_t nxt;
        bit     again;
        nxt = p;
        do
        begin
            again = 1'b0;
            sq_phase = nxt;
            case (nxt)
                PH_CMD_RESP, PH_RD_CRC, PH_WR_CRC:
                    sq_count = '0;
                PH_RD_POLL0:
                begin
                    sq_count = '0;
                    sq_polls = '0;
                    if (retry_limit == 0)
                    begin
                        nxt = PH_RD_POLLTOK;
                        again = 1'b1;
                    end
                end
                PH_RD_POLLTOK:
                begin
                    sq_polls = '0;
                    if (retry_limit == 0)
                    begin
                        nxt = PH_RD_SKIP;
                        again = 1'b1;
                    end
                end
                PH_RD_SKIP:
                    if (sq_skip == 0)
                    begin
                        nxt = PH_RD_DATA;
                        again = 1'b1;
                    end
                PH_RD_DATA:
                    if (sq_deliver == 0)
                    begin
                        nxt = PH_RD_REST;
                        again = 1'b1;
                    end
                PH_RD_REST:
                    if (sq_count >= BLOCK_BYTES)
                    begin
                        nxt = PH_RD_CRC;
                        again = 1'b1;
                    end
                PH_RD_BUSY:
                begin
                    sq_polls = '0;
                    if (retry_limit == 0)
                    begin
                        nxt = PH_IDLE;
                        again = 1'b1;
                    end
                end
                PH_WR_POLL0:
                begin
                    sq_polls = '0;
                    if (WR_POLL_LIMIT == 0)
                    begin
                        nxt = PH_WR_TOKEN;
                        again = 1'b1;
                    end
                end
                PH_WR_TOKEN:
                begin
                    sq_polls = '0;
                    if (WR_POLL_LIMIT == 0)
                    begin
                        nxt = PH_WR_DATA;
                        again = 1'b1;
                    end
                end
                PH_WR_DATA:
                    sq_count = '0;
                default:
                    sq_phase = PH_IDLE;
            endcase
        end
        while (again);
    endfunction

    function automatic void poll_advance(input bit hit, input logic [15:0] limit,
                                         input phase_t next_phase);
        sq_polls++;
        if (hit || sq_polls >= limit)
            enter_stage(next_phase);
    endfunction

    // One input beat through the sequencer; returns the result beat it causes.
    function automatic result_t sd_sequence_step(input beat_t b);
        result_t    r;
        logic [7:0] b0;
        logic [9:0] sk;
        logic [9:0] ln;
        r = '0;
        if (sq_phase == PH_IDLE)
        begin
            if (b.op == OP_EXCHANGE)
                return r;
            sq_count = '0;
            sq_polls = '0;
            sq_frame = b.arg;
            sq_crc = '0;
            sq_resp = '0;
            sq_skip = '0;
            sq_deliver = '0;
            if (b.op == OP_COMMAND)
            begin
                sq_phase = PH_CMD_FRAME;
                b0 = CMD_START | {2'b00, b.cmd};
            end
            else if (b.op == OP_READ)
            begin
                sq_phase = PH_RD_FRAME;
                b0 = CMD_READ17;
                sk = (b.skip > BLOCK_BYTES) ? 10'(BLOCK_BYTES) : b.skip;
                ln = (b.len > BLOCK_BYTES - sk) ? 10'(BLOCK_BYTES - sk) : b.len;
                sq_skip = sk;
                sq_deliver = ln;
            end
            else
            begin
                sq_phase = PH_WR_FRAME;
                b0 = CMD_WRITE24;
            end
            sq_crc = crc7_next(sq_crc, b0);
            r.exchange_now = 1'b1;
            r.mosi_byte = b0;
            r.chip_select = 1'b1;
            return r;
        end
        if (b.op != OP_EXCHANGE)
        begin
            r.chip_select = 1'b1;
            return r;
        end
        case (sq_phase)
            PH_CMD_FRAME, PH_RD_FRAME, PH_WR_FRAME:
            begin
                sq_count++;
                if (sq_count >= 6)
                    enter_stage(sq_phase == PH_CMD_FRAME ? PH_CMD_RESP :
                                sq_phase == PH_RD_FRAME ? PH_RD_POLL0 : PH_WR_POLL0);
            end
            PH_CMD_RESP:
            begin
                if (sq_count == 1)
                    sq_resp = b.miso;
                sq_count++;
                if (sq_count >= 8)
                    enter_stage(PH_IDLE);
            end
            PH_RD_POLL0:   poll_advance(b.miso == R1_READY, retry_limit, PH_RD_POLLTOK);
            PH_RD_POLLTOK: poll_advance(b.miso == TOKEN_START, retry_limit, PH_RD_SKIP);
            PH_RD_SKIP:
            begin
                sq_skip--;
                sq_count++;
                enter_stage(PH_RD_SKIP);
            end
            PH_RD_DATA:
            begin
                r.data_valid = 1'b1;
                r.data_byte = b.miso;
                sq_deliver--;
                sq_count++;
                enter_stage(PH_RD_DATA);
            end
            PH_RD_REST:
            begin
                sq_count++;
                enter_stage(PH_RD_REST);
            end
            PH_RD_CRC:
            begin
                sq_count++;
                if (sq_count >= 2)
                    enter_stage(PH_RD_BUSY);
            end
            PH_RD_BUSY:    poll_advance(b.miso == IDLE_BYTE, retry_limit, PH_IDLE);
            PH_WR_POLL0:   poll_advance(b.miso == R1_READY, WR_POLL_LIMIT, PH_WR_TOKEN);
            PH_WR_TOKEN:
                poll_advance((b.miso & DRESP_MASK) == DRESP_MASK, WR_POLL_LIMIT, PH_WR_DATA);
            PH_WR_DATA:
            begin
                sq_count++;
                if (sq_count >= BLOCK_BYTES)
                    enter_stage(PH_WR_CRC);
            end
            PH_WR_CRC:
            begin
                sq_count++;
                if (sq_count >= 2)
                    enter_stage(PH_IDLE);
            end
            default:
                enter_stage(PH_IDLE);
        endcase
        if (sq_phase == PH_IDLE)
        begin
            r.done_res = 1'b1;
            r.response_byte = sq_resp;
            return r;
        end
        case (sq_phase)
            PH_CMD_FRAME, PH_RD_FRAME, PH_WR_FRAME:
            begin
                if (sq_count < 5)
                begin
                    r.mosi_byte = sq_frame[31:24];
                    sq_frame = sq_frame << 8;
                    sq_crc = crc7_next(sq_crc, r.mosi_byte);
                end
                else if (sq_phase == PH_CMD_FRAME)
                    r.mosi_byte = {sq_crc, 1'b1};
                else if (sq_phase == PH_RD_FRAME)
                    r.mosi_byte = TOKEN_START;
                else
                    r.mosi_byte = IDLE_BYTE;
            end
            PH_WR_TOKEN:
                r.mosi_byte = TOKEN_START;
            PH_WR_DATA:
            begin
                r.write_taken = 1'b1;
                r.mosi_byte = b.wbyte;
            end
            default:
                r.mosi_byte = IDLE_BYTE;
        endcase
        r.exchange_now = 1'b1;
        r.chip_select = 1'b1;
        return r;
    endfunction

    // Card side: pick the next beat from the current model phase.
    function automatic beat_t card_beat();
        beat_t b;
        int    pick;
        bit    hit;
        b.op = OP_EXCHANGE;
        b.cmd = 6'($urandom);
        b.arg = $urandom;
        b.skip = 10'($urandom);
        b.len = 10'($urandom);
        b.miso = 8'($urandom);
        b.wbyte = 8'($urandom);
        hit = ($urandom_range(0, 3) == 0);
        if (sq_phase == PH_IDLE)
        begin
            pick = $urandom_range(0, 19);
            no_idle = ($urandom_range(0, 4) == 0);
            if (pick == 0)
                b.op = OP_EXCHANGE;
            else if (pick <= 10)
                b.op = OP_COMMAND;
            else if (pick <= 15)
            begin
                b.op = OP_READ;
                pick = $urandom_range(0, 3);
                if (pick == 1)
                begin
                    b.skip = 10'($urandom_range(0, 16));
                    b.len = 10'($urandom_range(0, 16));
                end
                else if (pick == 2)
                begin
                    b.skip = $urandom_range(0, 1) ? 10'(BLOCK_BYTES) : 10'd0;
                    b.len = $urandom_range(0, 1) ? 10'(BLOCK_BYTES) : 10'd0;
                end
                else if (pick == 3)
                begin
                    b.skip = 10'($urandom_range(0, BLOCK_BYTES));
                    b.len = 10'($urandom_range(0, BLOCK_BYTES - b.skip));
                end
            end
            else
                b.op = OP_WRITE;
        end
        else if ($urandom_range(0, 19) == 0)
            b.op = 2'($urandom_range(1, 3));
        else
        begin
            case (sq_phase)
                PH_RD_POLL0, PH_WR_POLL0:
                    if (hit)
                        b.miso = R1_READY;
                    else if (b.miso == R1_READY)
                        b.miso = b.miso ^ 8'h01;
                PH_RD_POLLTOK:
                    if (hit)
                        b.miso = TOKEN_START;
                    else if (b.miso == TOKEN_START)
                        b.miso = b.miso ^ 8'h01;
                PH_RD_BUSY:
                    if (hit)
                        b.miso = IDLE_BYTE;
                    else if (b.miso == IDLE_BYTE)
                        b.miso = b.miso ^ 8'h01;
                PH_WR_TOKEN:
                    if (hit)
                        b.miso = b.miso | DRESP_MASK;
                    else if ((b.miso & DRESP_MASK) == DRESP_MASK)
                        b.miso = b.miso ^ 8'h01;
                default:
                    b.miso = b.miso;
            endcase
        end
        return b;
    endfunction

    function automatic step_row_t table_row(input logic [1:0] op, input logic [5:0] cmd,
                                            input logic [31:0] arg, input logic [9:0] skip,
                                            input logic [9:0] len, input logic [7:0] miso,
                                            input logic typed, input result_t want,
                                            input logic finish);
        step_row_t s;
        s.item = {op, cmd, arg, skip, len, miso, ~miso};
        s.typed = typed;
        s.want = want;
        s.finish = finish;
        return s;
    endfunction

    function automatic result_t opening(input logic [7:0] first_byte);
        return result_t'({1'b1, first_byte, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00});
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("xchg=%0b mosi=%02h cs=%0b dv=%0b data=%02h wt=%0b done=%0b resp=%02h",
                         r.exchange_now, r.mosi_byte, r.chip_select, r.data_valid,
                         r.data_byte, r.write_taken, r.done_res, r.response_byte);
    endfunction

    // Drive one beat, hold it until taken, then log its expected result.
    task automatic send_beat(input beat_t b, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= b.op;
        command_index <= b.cmd;
        argument      <= b.arg;
        skip_count    <= b.skip;
        read_length   <= b.len;
        miso_byte     <= b.miso;
        write_byte    <= b.wbyte;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = sd_sequence_step(b);
        results_due.push_back(typed ? want : predicted);
    endtask

    // Register write with the sequencer idle and every result drained.
    task automatic program_retries(input logic [15:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        retry_limit = value;
    endtask

    initial
    begin : stimulus
        step_row_t   rows[$];
        logic [15:0] plan[$];
        beat_t       b;
        int          budget;
        int          taken;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        operation        = OP_EXCHANGE;
        command_index    = '0;
        argument         = '0;
        skip_count       = '0;
        read_length      = '0;
        miso_byte        = '0;
        write_byte       = '0;
        sq_phase    = PH_IDLE;
        sq_count    = '0;
        sq_polls    = '0;
        sq_frame    = '0;
        sq_crc      = '0;
        sq_skip     = '0;
        sq_deliver  = '0;
        sq_resp     = '0;
        retry_limit = RETRIES_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rows.push_back(table_row(OP_EXCHANGE, 6'd0, 32'h0, 10'd0, 10'd0, 8'h00,
                                 1'b1, NO_FIELDS, 1'b0));
        rows.push_back(table_row(OP_COMMAND, 6'd63, 32'hFFFF_FFFF, 10'd0, 10'd0, 8'hFF,
                                 1'b1, opening(8'h7F), 1'b0));
        rows.push_back(table_row(OP_EXCHANGE, 6'd0, 32'h0, 10'd0, 10'd0, 8'h00,
                                 1'b0, NO_FIELDS, 1'b0));
        rows.push_back(table_row(OP_READ, 6'd63, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 8'h00,
                                 1'b1, SELECT_ONLY, 1'b0));
        rows.push_back(table_row(OP_EXCHANGE, 6'd0, 32'h0, 10'd0, 10'd0, 8'hFF,
                                 1'b0, NO_FIELDS, 1'b0));
        rows.push_back(table_row(OP_WRITE, 6'd0, 32'h0, 10'd0, 10'd0, 8'h5A,
                                 1'b1, SELECT_ONLY, 1'b0));
        foreach (plan[i]) plan.delete(i);
        plan.push_back(16'h0055);
        plan.push_back(16'h00AA);
        plan.push_back(16'h000F);
        plan.push_back(16'h00F0);
        plan.push_back(16'h0080);
        plan.push_back(16'h00C3);
        plan.push_back(16'h0001);
        plan.push_back(16'h007E);
        plan.push_back(16'h00FF);
        plan.push_back(16'h0000);
        plan.push_back(16'h003C);
        foreach (plan[i])
            rows.push_back(table_row(OP_EXCHANGE, 6'd0, 32'h0, 10'd0, 10'd0, plan[i][7:0],
                                     1'b0, NO_FIELDS, 1'b0));
        // second response byte was C3
        rows.push_back(table_row(OP_EXCHANGE, 6'd0, 32'h0, 10'd0, 10'd0, 8'h99, 1'b1,
                                 result_t'({1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1,
                                            8'hC3}), 1'b0));
        rows.push_back(table_row(OP_COMMAND, 6'd0, 32'h0, 10'd0, 10'd0, 8'h00,
                                 1'b1, opening(CMD_START), 1'b1));
        rows.push_back(table_row(OP_WRITE, 6'd0, 32'h1234_5678, 10'd0, 10'd0, 8'h00,
                                 1'b1, opening(CMD_WRITE24), 1'b1));
        rows.push_back(table_row(OP_READ, 6'd0, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 8'h00,
                                 1'b1, opening(CMD_READ17), 1'b1));
        rows.push_back(table_row(OP_READ, 6'd0, 32'h0000_0001, 10'd100, 10'd1023, 8'h00,
                                 1'b1, opening(CMD_READ17), 1'b1));
        rows.push_back(table_row(OP_READ, 6'd0, 32'h8000_0000, 10'd0, 10'd512, 8'h00,
                                 1'b1, opening(CMD_READ17), 1'b1));

        foreach (rows[i])
        begin
            send_beat(rows[i].item, rows[i].typed, rows[i].want);
            if (rows[i].finish)
                while (sq_phase != PH_IDLE)
                    send_beat(card_beat(), 1'b0, NO_FIELDS);
        end

        plan.delete();
        plan.push_back(16'd0);
        plan.push_back(16'd1);
        plan.push_back(16'hFFFF);
        plan.push_back(16'($urandom_range(2, 8)));
        plan.push_back(16'($urandom_range(9, 65534)));
        plan.push_back(RETRIES_RESET);
        budget = 1350 / plan.size();
        foreach (plan[i])
        begin
            program_retries(plan[i]);
            taken = 0;
            while (taken < budget || sq_phase != PH_IDLE)
            begin
                b = card_beat();
                if ((sq_phase == PH_IDLE) ? (b.op != OP_EXCHANGE) : (b.op == OP_EXCHANGE))
                    taken++;
                send_beat(b, 1'b0, NO_FIELDS);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (bad_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = result_t'({exchange_now, mosi_byte, chip_select, data_valid, data_byte,
                             write_taken, done_res, response_byte});
            if (results_due.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("beat %0d: result with none pending: %s", result_index, show(got));
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("beat %0d mismatch\n  exp %s\n  got %s",
                                 result_index, show(want), show(got));
                end
            end
            result_index++;
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/core/sdspi_pkg.sv
rtl/core/sd_spi_block_transfer_sequencer_core.sv
tb/sd_spi_block_transfer_sequencer_core_tb.sv
